[rtl/scroll_easing_animator_defines.svh]
// ----------------------------------------------------------------------------
// Scroll easing animator assertion macros
// Shared property wrappers for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SCROLL_EASING_ANIMATOR_DEFINES_SVH
`define SCROLL_EASING_ANIMATOR_DEFINES_SVH

// same-cycle implication
`define SEA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SEA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sea_pkg.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator package
// Shared codes, widths, controller/datapath types and curve tables.
// ----------------------------------------------------------------------------
package sea_pkg;

   localparam int CURVE_SAMPLES = 128;
   localparam int IDX_W = $clog2(CURVE_SAMPLES);
   localparam int ROM_AW = $clog2(CURVE_SAMPLES + 1);
   localparam int DIV_W = 43;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   localparam logic [1:0] MODE_SPLINE = 2'd0;
   localparam logic [1:0] MODE_FLUID = 2'd1;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_EVAL, OP_QSTART, OP_CAPQ, OP_EASE1, OP_EASE2, OP_EASE3,
      OP_POS1, OP_POS2, OP_VEL1, OP_VSTART, OP_COMMIT, OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic run_tick;
      logic div_done;
      logic out_busy;
   } stat_type;

   typedef logic [16:0] curve_rom_type [0:CURVE_SAMPLES];

   localparam logic [63:0] Q30 = 64'd1 << 30;
   localparam logic [63:0] SPL_P = Q30 * 64'd140 / 64'd1000;
   localparam logic [63:0] SPL_Q1 = Q30 * 64'd4 / 64'd10;
   localparam logic [63:0] SPL_Q2 = Q30 * 64'd6 / 64'd10;
   localparam logic [63:0] SPL_TOL = 64'd10737;

   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   // shift-subtract long division, only used while building the tables
   function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[63:0], a[k]};
         if (rem >= {1'b0, b}) begin
            rem = rem - {1'b0, b};
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^-f in Q2.30 for f in [0, 1], truncated series
   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0] sum;
      logic [63:0] term;
      sum = Q30;
      term = Q30;
      for (int n = 1; n < 24; n++) begin
         term = udiv64(term * f, 64'(n) * Q30);
         sum = sum + term;
      end
      return udiv64(64'd1 << 60, sum);
   endfunction

   function automatic logic [63:0] exp_neg(input logic [63:0] z);
      logic [63:0] inv_e;
      logic [63:0] r;
      logic [63:0] k;
      inv_e = exp_neg_frac(Q30);
      r = exp_neg_frac(z & (Q30 - 64'd1));
      k = z >> 30;
      for (int j = 0; j < 16; j++) begin
         if (64'(j) < k) r = qmul(r, inv_e);
      end
      return r;
   endfunction

   function automatic longint fluid_g(input logic [63:0] y);
      logic [63:0] inv_e;
      longint g;
      inv_e = exp_neg_frac(Q30);
      if (y < Q30) begin
         g = longint'(y) - longint'(Q30) + longint'(exp_neg(y));
         return (g < 0) ? 64'sd0 : g;
      end
      return longint'(inv_e + qmul(Q30 - exp_neg(y - Q30), Q30 - inv_e));
   endfunction

   function automatic curve_rom_type build_spline();
      curve_rom_type rom;
      logic [63:0] xmin, xmax, x, om, coef, cube, s, t, tx, diff;
      logic fnd;
      xmin = 64'd0;
      for (int i = 0; i < CURVE_SAMPLES; i++) begin
         t = (Q30 * 64'(i)) / 64'(CURVE_SAMPLES);
         xmax = Q30;
         x = 64'd0;
         om = Q30;
         coef = 64'd0;
         cube = 64'd0;
         fnd = 1'b0;
         for (int it = 0; it < 64; it++) begin
            if (!fnd) begin
               x = xmin + (xmax - xmin) / 64'd2;
               om = Q30 - x;
               coef = 64'd3 * qmul(x, om);
               cube = qmul(qmul(x, x), x);
               tx = qmul(coef, SPL_P) + cube;
               diff = (tx > t) ? tx - t : t - tx;
               if (diff < SPL_TOL) fnd = 1'b1;
               else if (tx > t) xmax = x;
               else xmin = x;
            end
         end
         s = qmul(coef, qmul(om, SPL_Q1) + qmul(x, SPL_Q2)) + cube;
         rom[i] = 17'((s + (64'd1 << 13)) >> 14);
      end
      rom[CURVE_SAMPLES] = 17'd65536;
      return rom;
   endfunction

   // g is never negative and g8 is positive, so unsigned division rounds alike
   function automatic curve_rom_type build_fluid();
      curve_rom_type rom;
      longint g8;
      longint g;
      logic [63:0] y;
      g8 = fluid_g(64'd8 * Q30);
      for (int i = 0; i <= CURVE_SAMPLES; i++) begin
         y = (64'd8 * Q30 * 64'(i)) / 64'(CURVE_SAMPLES);
         g = fluid_g(y);
         rom[i] = 17'(udiv64(64'(g) * 64'd65536 + (64'(g8) >> 1), 64'(g8)));
      end
      return rom;
   endfunction

   localparam curve_rom_type SPLINE_ROM = build_spline();
   localparam curve_rom_type FLUID_ROM = build_fluid();

endpackage

[rtl/scroll_easing_animator.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator
// Eases a scroll position between start and finish points on tick events.
//
//   channel   direction  transfer condition
//   req_*     in         req_valid & req_ready
//   rsp_*     out        rsp_valid & rsp_ready
//   csr_*     in         csr_wr_en (single register: curve mode)
//
// Start, finish, ignored and non-running ticks go from evaluate straight to the
// output register. A running tick adds two passes of the bit-per-cycle 43-step
// divider (fraction, then velocity) and the ease, position and velocity control
// and arithmetic steps.
// One event is in flight at a time; a new one is taken while the last result
// waits in the output register, and the controller holds its next result until
// that one transfers. Reset is synchronous, tables are constant.
// ----------------------------------------------------------------------------
`include "scroll_easing_animator_defines.svh"

module scroll_easing_animator (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_time_ms,
   input  logic signed [31:0] req_start_position,
   input  logic signed [31:0] req_distance,
   input  logic [15:0]        req_duration_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_scrolling,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity
);
   import sea_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sea_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_action         (req_action),
      .req_time_ms        (req_time_ms),
      .req_start_position (req_start_position),
      .req_distance       (req_distance),
      .req_duration_ms    (req_duration_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scrolling      (rsp_scrolling),
      .rsp_position       (rsp_position),
      .rsp_velocity       (rsp_velocity)
   );

   `SEA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second event taken while one in flight")
   `SEA_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "result raised right after transfer")
   `SEA_ASSERT_NOW(a_publish_free, clock, reset, cmd.op == OP_PUBLISH, !rsp_valid || rsp_ready, "result register overwritten")

endmodule

[rtl/sea_div.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator divider
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module sea_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sea_pkg::DIV_W-1:0]  numer,
   input  logic [15:0]                denom,
   output logic                       done,
   output logic [sea_pkg::DIV_W-1:0]  quot
);
   import sea_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]       rem_ff, rem_in;
   logic [15:0]       den_ff, den_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [16:0]       trial;
   logic              ge;

   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign ge = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      num_in = num_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = DCNT_W'(DIV_W);
         rem_in = '0;
         den_in = denom;
         num_in = numer;
      end else if (busy_ff) begin
         rem_in = ge ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         num_in = {num_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

[rtl/sea_dp.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator datapath
// Scroll state, easing arithmetic, shared divider and result register.
// ----------------------------------------------------------------------------
module sea_dp (
   input  logic                clock,
   input  logic                reset,
   input  sea_pkg::cmd_type    cmd,
   output sea_pkg::stat_type   stat,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_wr_data,
   input  logic [1:0]          req_action,
   input  logic [31:0]         req_time_ms,
   input  logic signed [31:0]  req_start_position,
   input  logic signed [31:0]  req_distance,
   input  logic [15:0]         req_duration_ms,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_scrolling,
   output logic signed [31:0]  rsp_position,
   output logic signed [31:0]  rsp_velocity
);
   import sea_pkg::*;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

   logic [1:0]          mode_ff;
   logic [1:0]          in_act_ff;
   logic [31:0]         in_time_ff;
   logic signed [31:0]  in_start_ff, in_dist_ff;
   logic [15:0]         in_dur_ff;

   logic                active_ff;
   logic signed [31:0]  origin_ff, target_ff, now_pos_ff, now_vel_ff;
   logic [31:0]         begin_ff;
   logic [15:0]         span_ff;

   logic [15:0]         elapsed_ff, q_ff, frac_ff, q2_ff, q3_ff;
   logic [16:0]         ra_ff, rb_ff, eased_ff;
   logic signed [34:0]  lerp_ff;
   logic signed [50:0]  prod_ff;
   logic signed [31:0]  pos_new_ff;
   logic                vneg_ff;
   logic [DIV_W-1:0]    vmag_ff;

   logic                out_valid_ff, out_scr_ff;
   logic signed [31:0]  out_pos_ff, out_vel_ff;

   logic [31:0]         elapsed32;
   logic                run_tick;
   logic signed [32:0]  sum33;
   logic signed [31:0]  target_sat;
   logic [16+IDX_W-1:0] pidx;
   logic [ROM_AW-1:0]   idx;
   logic                use_table;
   logic signed [17:0]  eased_tab, eased_smooth;
   logic signed [34:0]  pos_sum;
   logic signed [31:0]  pos_sat;
   logic signed [32:0]  delta;
   logic signed [43:0]  vprod;
   logic                div_start, div_done;
   logic [DIV_W-1:0]    div_numer, div_quot;
   logic [15:0]         div_denom;
   logic signed [31:0]  vel_sat;

   assign elapsed32 = (begin_ff < in_time_ff) ? in_time_ff - begin_ff : 32'd0;
   assign run_tick = (in_act_ff == ACT_TICK) && active_ff && (elapsed32 < {16'd0, span_ff});

   assign sum33 = 33'(in_start_ff) + 33'(in_dist_ff);
   assign target_sat = (sum33[32] != sum33[31]) ? (sum33[32] ? POS_MIN : POS_MAX)
                                                : sum33[31:0];

   assign use_table = (mode_ff == MODE_SPLINE) || (mode_ff == MODE_FLUID);
   assign pidx = (16+IDX_W)'(q_ff) * (16+IDX_W)'(CURVE_SAMPLES);
   assign idx = ROM_AW'(pidx[16+IDX_W-1:16]);

   assign eased_tab = $signed({1'b0, ra_ff}) + 18'(lerp_ff >>> 16);
   assign eased_smooth = $signed(18'(3 * {2'b0, q2_ff})) - $signed(18'(2 * {2'b0, q3_ff}));

   assign pos_sum = 35'(origin_ff) + 35'(prod_ff >>> 16);
   assign pos_sat = (pos_sum > 35'(POS_MAX)) ? POS_MAX
                  : (pos_sum < 35'(POS_MIN)) ? POS_MIN : pos_sum[31:0];

   assign delta = 33'(pos_new_ff) - 33'(now_pos_ff);
   assign vprod = 44'(delta) * 44'sd1000;

   assign div_start = (cmd.op == OP_QSTART) || (cmd.op == OP_VSTART);
   assign div_numer = (cmd.op == OP_QSTART) ? {11'd0, elapsed_ff, 16'd0} : vmag_ff;
   assign div_denom = (cmd.op == OP_QSTART) ? span_ff : elapsed_ff;

   // truncating quotient, then clamp to the 32-bit signed range
   always_comb begin
      if (vneg_ff) begin
         vel_sat = (div_quot > DIV_W'(33'h0_8000_0000)) ? POS_MIN : -$signed(div_quot[31:0]);
      end else begin
         vel_sat = (div_quot > DIV_W'(32'h7FFF_FFFF)) ? POS_MAX : $signed(div_quot[31:0]);
      end
   end

   sea_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (div_denom),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SPLINE;
         active_ff <= 1'b0;
         origin_ff <= '0;
         target_ff <= '0;
         begin_ff <= '0;
         span_ff <= '0;
         now_pos_ff <= '0;
         now_vel_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) mode_ff <= csr_wr_data;
         if (cmd.op == OP_PUBLISH) out_valid_ff <= 1'b1;
         else if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         unique case (cmd.op)
            OP_EVAL: begin
               priority if (in_act_ff == ACT_START) begin
                  active_ff <= 1'b1;
                  origin_ff <= in_start_ff;
                  target_ff <= target_sat;
                  begin_ff <= in_time_ff;
                  span_ff <= in_dur_ff;
                  now_vel_ff <= '0;
               end else if ((in_act_ff == ACT_FINISH) ||
                            ((in_act_ff == ACT_TICK) && active_ff && !run_tick)) begin
                  now_pos_ff <= target_ff;
                  now_vel_ff <= '0;
                  active_ff <= 1'b0;
               end else begin
               end
            end
            OP_COMMIT: begin
               now_pos_ff <= pos_new_ff;
               now_vel_ff <= (elapsed_ff == 16'd0) ? 32'sd0 : vel_sat;
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            in_act_ff <= req_action;
            in_time_ff <= req_time_ms;
            in_start_ff <= req_start_position;
            in_dist_ff <= req_distance;
            in_dur_ff <= req_duration_ms;
         end
         OP_EVAL: elapsed_ff <= elapsed32[15:0];
         OP_CAPQ: q_ff <= div_quot[15:0];
         OP_EASE1: begin
            ra_ff <= (mode_ff == MODE_SPLINE) ? SPLINE_ROM[idx] : FLUID_ROM[idx];
            rb_ff <= (mode_ff == MODE_SPLINE) ? SPLINE_ROM[idx + ROM_AW'(1)]
                                              : FLUID_ROM[idx + ROM_AW'(1)];
            frac_ff <= pidx[15:0];
            q2_ff <= 16'(({16'd0, q_ff} * {16'd0, q_ff}) >> 16);
         end
         OP_EASE2: begin
            lerp_ff <= 35'($signed({1'b0, rb_ff}) - $signed({1'b0, ra_ff}))
                       * 35'($signed({1'b0, frac_ff}));
            q3_ff <= 16'(({16'd0, q2_ff} * {16'd0, q_ff}) >> 16);
         end
         OP_EASE3: eased_ff <= use_table ? eased_tab[16:0] : eased_smooth[16:0];
         OP_POS1: prod_ff <= 51'($signed({1'b0, eased_ff}))
                             * 51'(33'(target_ff) - 33'(origin_ff));
         OP_POS2: pos_new_ff <= pos_sat;
         OP_VEL1: begin
            vneg_ff <= vprod[43];
            vmag_ff <= vprod[43] ? DIV_W'(-vprod) : DIV_W'(vprod);
         end
         OP_PUBLISH: begin
            out_scr_ff <= active_ff;
            out_pos_ff <= now_pos_ff;
            out_vel_ff <= now_vel_ff;
         end
         default: begin
         end
      endcase
   end

   assign stat.run_tick = run_tick;
   assign stat.div_done = div_done;
   assign stat.out_busy = out_valid_ff && !rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_scrolling = out_scr_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_velocity = out_vel_ff;

endmodule

[rtl/sea_ctrl.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator controller
// Sequences one event through evaluate and, for a running tick, divide, ease,
// position and velocity.
module sea_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sea_pkg::stat_type  stat,
   output sea_pkg::cmd_type   cmd
);
   import sea_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0_0000_0000_0001,
      ST_EVAL   = 13'b0_0000_0000_0010,
      ST_QSTART = 13'b0_0000_0000_0100,
      ST_QWAIT  = 13'b0_0000_0000_1000,
      ST_EASE1  = 13'b0_0000_0001_0000,
      ST_EASE2  = 13'b0_0000_0010_0000,
      ST_EASE3  = 13'b0_0000_0100_0000,
      ST_POS1   = 13'b0_0000_1000_0000,
      ST_POS2   = 13'b0_0001_0000_0000,
      ST_VEL1   = 13'b0_0010_0000_0000,
      ST_VSTART = 13'b0_0100_0000_0000,
      ST_VWAIT  = 13'b0_1000_0000_0000,
      ST_DONE   = 13'b1_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.op = OP_LOAD;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.op = OP_EVAL;
            state_in = stat.run_tick ? ST_QSTART : ST_DONE;
         end
         ST_QSTART: begin
            cmd.op = OP_QSTART;
            state_in = ST_QWAIT;
         end
         ST_QWAIT: if (stat.div_done) begin
            cmd.op = OP_CAPQ;
            state_in = ST_EASE1;
         end
         ST_EASE1: begin
            cmd.op = OP_EASE1;
            state_in = ST_EASE2;
         end
         ST_EASE2: begin
            cmd.op = OP_EASE2;
            state_in = ST_EASE3;
         end
         ST_EASE3: begin
            cmd.op = OP_EASE3;
            state_in = ST_POS1;
         end
         ST_POS1: begin
            cmd.op = OP_POS1;
            state_in = ST_POS2;
         end
         ST_POS2: begin
            cmd.op = OP_POS2;
            state_in = ST_VEL1;
         end
         ST_VEL1: begin
            cmd.op = OP_VEL1;
            state_in = ST_VSTART;
         end
         ST_VSTART: begin
            cmd.op = OP_VSTART;
            state_in = ST_VWAIT;
         end
         ST_VWAIT: if (stat.div_done) begin
            cmd.op = OP_COMMIT;
            state_in = ST_DONE;
         end
         ST_DONE: if (!stat.out_busy) begin
            cmd.op = OP_PUBLISH;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

[sim/sea_checker.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator checker
// Watches the request, response and CSR ports and predicts each response
// from the accepted event. Compares responses in order, field by field.
// ----------------------------------------------------------------------------
module sea_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_time_ms,
   input  logic signed [31:0] req_start_position,
   input  logic signed [31:0] req_distance,
   input  logic [15:0]        req_duration_ms,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_scrolling,
   input  logic signed [31:0] rsp_position,
   input  logic signed [31:0] rsp_velocity,
   output int                 pending,
   output int                 errors,
   output int                 ticks_run
);
   import sea_pkg::*;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam int NSAMP = CURVE_SAMPLES;

   typedef struct {
      logic               scrolling;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
   } anim_out_type;

   anim_out_type  expected_q[$];
   logic [16:0]   spline_tab [0:NSAMP];
   logic [16:0]   fluid_tab [0:NSAMP];

   // animation state
   logic          run_active;
   longint        from_pos, to_pos, cur_pos, cur_vel;
   logic [31:0]   t_begin;
   logic [15:0]   span;
   logic [1:0]    curve_sel;

   function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   function automatic logic [63:0] expm_frac(input logic [63:0] f);
      logic [63:0] acc, term;
      acc = ONE_Q30;
      term = ONE_Q30;
      for (int n = 1; n < 24; n++) begin
         term = (term * f) / (64'(n) * ONE_Q30);
         acc = acc + term;
      end
      return (64'd1 << 60) / acc;
   endfunction

   function automatic logic [63:0] expm(input logic [63:0] z);
      logic [63:0] r, inv_e, whole;
      inv_e = expm_frac(ONE_Q30);
      r = expm_frac(z & (ONE_Q30 - 1));
      whole = z >> 30;
      while (whole > 0) begin
         r = mul_q30(r, inv_e);
         whole = whole - 1;
      end
      return r;
   endfunction

   function automatic longint viscous_g(input logic [63:0] y);
      logic [63:0] inv_e;
      longint v;
      inv_e = expm_frac(ONE_Q30);
      if (y < ONE_Q30) begin
         v = longint'(y) - longint'(ONE_Q30) + longint'(expm(y));
         return (v < 0) ? 0 : v;
      end
      return longint'(inv_e + mul_q30(ONE_Q30 - expm(y - ONE_Q30), ONE_Q30 - inv_e));
   endfunction

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint eased_frac(input logic [63:0] q, input logic [1:0] sel);
      logic [63:0] p, q2, q3;
      longint a, b, fr;
      int idx;
      if (sel == MODE_SPLINE || sel == MODE_FLUID) begin
         p = q * NSAMP;
         idx = int'(p >> 16);
         if (idx >= NSAMP) idx = NSAMP - 1;
         fr = longint'(p & 64'hFFFF);
         a = (sel == MODE_SPLINE) ? longint'(spline_tab[idx]) : longint'(fluid_tab[idx]);
         b = (sel == MODE_SPLINE) ? longint'(spline_tab[idx+1]) : longint'(fluid_tab[idx+1]);
         return a + (((b - a) * fr) >>> 16);
      end
      q2 = (q * q) >> 16;
      q3 = (q2 * q) >> 16;
      return 3 * longint'(q2) - 2 * longint'(q3);
   endfunction

   function automatic anim_out_type next_frame(input logic [1:0] act, input logic [31:0] now,
                                               input logic signed [31:0] spos,
                                               input logic signed [31:0] move_by,
                                               input logic [15:0] dur);
      anim_out_type o;
      logic [31:0] elapsed;
      logic [63:0] q;
      longint e, prev;
      case (act)
         ACT_START: begin
            run_active = 1'b1;
            from_pos = longint'(spos);
            to_pos = clip32(from_pos + longint'(move_by));
            t_begin = now;
            span = dur;
            cur_vel = 0;
         end
         ACT_TICK: begin
            if (run_active) begin
               elapsed = now - ((t_begin < now) ? t_begin : now);
               if (elapsed < {16'd0, span}) begin
                  ticks_run++;
                  q = {elapsed, 16'd0} / {48'd0, span};
                  e = eased_frac(q, curve_sel);
                  prev = cur_pos;
                  cur_pos = clip32(from_pos + ((e * (to_pos - from_pos)) >>> 16));
                  if (elapsed == 0) cur_vel = 0;
                  else cur_vel = clip32(((cur_pos - prev) * 1000) / longint'(elapsed));
               end else begin
                  cur_pos = to_pos;
                  cur_vel = 0;
                  run_active = 1'b0;
               end
            end
         end
         ACT_FINISH: begin
            cur_pos = to_pos;
            cur_vel = 0;
            run_active = 1'b0;
         end
         default: ;
      endcase
      o.scrolling = run_active;
      o.position = cur_pos[31:0];
      o.velocity = cur_vel[31:0];
      return o;
   endfunction

   // curve tables, built once
   initial begin
      logic [63:0] xlo, xhi, x, om, coef, cube, s, t, tx, diff, y;
      longint g8, g;
      xlo = 0;
      for (int i = 0; i < NSAMP; i++) begin
         t = (ONE_Q30 * 64'(i)) / NSAMP;
         xhi = ONE_Q30;
         x = 0; om = ONE_Q30; coef = 0; cube = 0;
         for (int it = 0; it < 64; it++) begin
            x = xlo + (xhi - xlo) / 2;
            om = ONE_Q30 - x;
            coef = 3 * mul_q30(x, om);
            cube = mul_q30(mul_q30(x, x), x);
            tx = mul_q30(coef, ONE_Q30 * 140 / 1000) + cube;
            diff = (tx > t) ? tx - t : t - tx;
            if (diff < 64'd10737) break;
            if (tx > t) xhi = x; else xlo = x;
         end
         s = mul_q30(coef, mul_q30(om, ONE_Q30 * 4 / 10) + mul_q30(x, ONE_Q30 * 6 / 10))
             + cube;
         spline_tab[i] = 17'((s + (64'd1 << 13)) >> 14);
      end
      spline_tab[NSAMP] = 17'd65536;
      g8 = viscous_g(8 * ONE_Q30);
      for (int i = 0; i <= NSAMP; i++) begin
         y = (8 * ONE_Q30 * 64'(i)) / NSAMP;
         g = viscous_g(y);
         fluid_tab[i] = 17'((g * 65536 + g8 / 2) / g8);
      end
   end

   initial begin
      errors = 0;
      ticks_run = 0;
   end

   assign pending = expected_q.size();

   always @(posedge clock) begin
      anim_out_type exp_o;
      if (reset) begin
         from_pos = 0; to_pos = 0; cur_pos = 0; cur_vel = 0;
         t_begin = 0; span = 0; curve_sel = MODE_SPLINE;
         run_active = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) curve_sel = csr_wr_data;
         if (req_valid && req_ready)
            expected_q.push_back(next_frame(req_action, req_time_ms, req_start_position,
                                            req_distance, req_duration_ms));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response transfer with no event outstanding");
               errors++;
            end else begin
               exp_o = expected_q.pop_front();
               if (rsp_scrolling !== exp_o.scrolling) begin
                  $error("scrolling: expected %0d got %0d", exp_o.scrolling, rsp_scrolling);
                  errors++;
               end
               if (rsp_position !== exp_o.position) begin
                  $error("position: expected %0d got %0d", exp_o.position, rsp_position);
                  errors++;
               end
               if (rsp_velocity !== exp_o.velocity) begin
                  $error("velocity: expected %0d got %0d", exp_o.velocity, rsp_velocity);
                  errors++;
               end
            end
         end
      end
   end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Scroll easing animator testbench
// Directed corner events, then random scroll sequences under each curve
// mode, with bursty requests, response stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import sea_pkg::*;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam logic [1:0] MODE_SMOOTH = 2'd2;
   localparam logic [1:0] MODE_ALIAS = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = '0;
   logic [31:0]        req_time_ms = '0;
   logic signed [31:0] req_start_position = '0;
   logic signed [31:0] req_distance = '0;
   logic [15:0]        req_duration_ms = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_scrolling;
   logic signed [31:0] rsp_position;
   logic signed [31:0] rsp_velocity;

   int   pending, errors, ticks_run;
   int   burst_left = 0;
   int   sent = 0;
   logic hold_off_req = 1'b0;

   always #6 clock = ~clock;

   scroll_easing_animator DUT (.*);

   sea_checker u_checker (.*);

   // receiver: changing stall pattern, plus one long hold-off on request
   initial begin
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            case ((cyc / 97) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= (cyc % 3 == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_event(input logic [1:0] act, input logic [31:0] t,
                             input logic [31:0] spos, input logic [31:0] move_by,
                             input logic [15:0] dur);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_time_ms <= t;
      req_start_position <= spos;
      req_distance <= move_by;
      req_duration_ms <= dur;
      do @(posedge clock); while (!(req_valid && req_ready));
      burst_left--;
      sent++;
   endtask

   task automatic drain_and_set_mode(input logic [1:0] mode);
      if (req_valid) req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one start, a run of ticks, then a finish or an overrun tick
   task automatic scroll_sequence();
      logic [31:0] t0, t;
      logic [31:0] move_by;
      logic [15:0] dur;
      int n;
      t0 = $urandom;
      case ($urandom_range(0, 9))
         0: dur = 16'($urandom);
         1: dur = 16'($urandom_range(0, 3));
         default: dur = 16'($urandom_range(4, 600));
      endcase
      move_by = ($urandom_range(0, 2) == 0) ? $urandom
                : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      send_event(ACT_START, t0, $urandom, move_by, dur);
      n = $urandom_range(1, 8);
      t = t0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) t = t0 - $urandom_range(1, 1000);
         else if ($urandom_range(0, 7) == 0) t = t;
         else t = t0 + $urandom_range(0, {16'd0, dur} + 1) ;
         send_event(ACT_TICK, t, $urandom, $urandom, 16'($urandom));
      end
      if ($urandom_range(0, 2) == 0) send_event(ACT_FINISH, $urandom, $urandom, $urandom,
                                                16'($urandom));
      else send_event(ACT_TICK, t0 + dur + $urandom_range(0, 50), $urandom, $urandom,
                      16'($urandom));
   endtask

   initial begin
      logic [1:0] modes [5] = '{MODE_FLUID, MODE_SPLINE, MODE_ALIAS, MODE_SMOOTH, MODE_FLUID};
      bit held_once;
      held_once = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_event(ACT_TICK, 32'd5, 0, 0, 16'd0);                    // tick while idle
      send_event(ACT_FINISH, 0, 0, 0, 16'd0);                      // finish while idle
      send_event(ACT_IGNORED, '1, '1, '1, '1);                     // unused action
      send_event(ACT_START, 32'd100, 32'h0001_0000, 32'h0064_0000, 16'd200);
      send_event(ACT_TICK, 32'd100, 0, 0, 16'd0);                  // zero elapsed
      send_event(ACT_TICK, 32'd150, 0, 0, 16'd0);
      send_event(ACT_TICK, 32'd50, 0, 0, 16'd0);                   // time before start
      send_event(ACT_TICK, 32'd299, 0, 0, 16'd0);
      send_event(ACT_TICK, 32'd300, 0, 0, 16'd0);                  // reaches duration
      send_event(ACT_START, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF); // saturate up
      send_event(ACT_TICK, 32'd40000, 0, 0, 16'd0);                // time wraps past start
      send_event(ACT_IGNORED, 0, 0, 0, 16'd0);
      send_event(ACT_START, 0, 32'h8000_0000, 32'h8000_0000, 16'd1000); // saturate down
      send_event(ACT_TICK, 32'd1, 0, 0, 16'd0);
      send_event(ACT_TICK, 32'd999, 0, 0, 16'd0);
      send_event(ACT_START, 32'd7, 32'h8000_0000, 32'h7FFF_FFFF, 16'd2);
      send_event(ACT_TICK, 32'd8, 0, 0, 16'd0);                    // huge velocity
      send_event(ACT_START, 32'd7, 0, 32'd12345, 16'd0);           // zero duration
      send_event(ACT_TICK, 32'd7, 0, 0, 16'd0);
      send_event(ACT_FINISH, 0, 0, 0, 16'd0);

      foreach (modes[m]) begin
         drain_and_set_mode(modes[m]);
         while (sent < 20 + 80 * (m + 1)) begin
            if (m == 2 && !held_once && sent > 200) begin
               hold_off_req = 1'b1;
               held_once = 1'b1;
            end
            if ($urandom_range(0, 5) == 0)
               send_event(2'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
            else
               scroll_sequence();
         end
      end

      if (req_valid) req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (120) @(posedge clock);
      $display("Sent %0d events over all curve modes; %0d ticks eased mid-scroll.",
               sent, ticks_run);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
